>>> hw/rtl/tfnm_pkg.sv
package tfnm_pkg;

  localparam int unsigned VW = 24;
  localparam int unsigned EW = 20;
  localparam int unsigned CW = 23;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic          mode;
    logic [EW-1:0] element_id;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
    logic [VW-1:0] vertex_c;
    logic [VW-1:0] vertex_d;
  } in_item_t;

  typedef struct packed {
    logic [EW-1:0] this_element;
    logic [1:0]    face_index;
    logic          matched;
    logic [EW-1:0] neighbor_element;
    logic [1:0]    neighbor_face;
    logic [CW-1:0] surface_total;
    logic [CW-1:0] inner_total;
    logic          table_full;
    logic          last;
  } out_item_t;

  // One face job handed from the front part to the probe engine.
  typedef struct packed {
    logic          clear;
    logic [EW-1:0] elem;
    logic [1:0]    face;
    logic [VW-1:0] hi;
    logic [VW-1:0] mid;
    logic [VW-1:0] lo;
  } face_job_t;

endpackage

>>> hw/rtl/tfnm_front.sv
module tfnm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tfnm_pkg::in_item_t  in_data,
  output logic                job_valid,
  input  logic                job_ready,
  output tfnm_pkg::face_job_t job
);

  tfnm_pkg::in_item_t item_r;
  logic               busy_r;
  logic [1:0]         face_r;
  logic [tfnm_pkg::VW-1:0] a, b, c, t0, t1, t2, m0, m1, m2;

  assign in_ready  = !busy_r;
  assign job_valid = busy_r;

  // Face f takes vertices f+1, f+2, f+3 (mod 4).
  always_comb begin
    case (face_r)
      2'd0: begin a = item_r.vertex_b; b = item_r.vertex_c; c = item_r.vertex_d; end
      2'd1: begin a = item_r.vertex_c; b = item_r.vertex_d; c = item_r.vertex_a; end
      2'd2: begin a = item_r.vertex_d; b = item_r.vertex_a; c = item_r.vertex_b; end
      default: begin a = item_r.vertex_a; b = item_r.vertex_b; c = item_r.vertex_c; end
    endcase
    t0 = (a < b) ? b : a;
    t1 = (a < b) ? a : b;
    m1 = (t1 < c) ? c : t1;
    t2 = (t1 < c) ? t1 : c;
    m0 = (t0 < m1) ? m1 : t0;
    m2 = (t0 < m1) ? t0 : m1;
    job.clear = item_r.mode == tfnm_pkg::MODE_CLEAR;
    job.elem  = item_r.element_id;
    job.face  = face_r;
    job.hi    = m0;
    job.mid   = m2;
    job.lo    = t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      face_r <= 2'd0;
    end else if (!busy_r) begin
      if (in_valid) begin
        busy_r <= 1'b1;
        face_r <= 2'd0;
      end
    end else if (job_ready) begin
      face_r <= face_r + 2'd1;
      if (job.clear || face_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && in_valid) begin
      item_r <= in_data;
    end
  end

endmodule

>>> hw/rtl/tfnm_fifo.sv
module tfnm_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  tfnm_pkg::face_job_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output tfnm_pkg::face_job_t rd_data
);

  tfnm_pkg::face_job_t mem_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= !wp_r;
      if (rd_valid && rd_ready) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

endmodule

>>> hw/rtl/tfnm_probe.sv
module tfnm_probe #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned AW          = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [3:0]           size_log2,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  tfnm_pkg::face_job_t  job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tfnm_pkg::out_item_t  out_data,
  output logic                 clearing
);

  localparam int unsigned VW = tfnm_pkg::VW;
  localparam int unsigned EW = tfnm_pkg::EW;
  localparam int unsigned CW = tfnm_pkg::CW;
  localparam int unsigned SW = AW + 1;

  typedef enum logic [5:0] {
    S_CLR   = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [VW-1:0] hi;
    logic [VW-1:0] mid;
    logic [VW-1:0] lo;
    logic [EW-1:0] elem;
    logic [1:0]    face;
  } entry_t;

  entry_t     ent_mem [TABLE_DEPTH];
  logic [2:0] occ_mem [TABLE_DEPTH];
  entry_t     ent_q;
  logic [2:0] occ_q;

  state_t              st_r;
  tfnm_pkg::face_job_t job_r;
  logic [AW-1:0]       h_r, clr_r;
  logic [SW-1:0]       probes_r;
  logic [AW-1:0]       mask;
  logic [SW-1:0]       size;
  logic [CW-1:0]       surf_r, inner_r;
  logic                full_r, ovalid_r;
  tfnm_pkg::out_item_t obuf_r, res_r;
  logic [VW+10:0]      hsum_r;
  logic [3:0]          lg;
  logic                hit, wr_en;
  logic [2:0]          nc;

  always_comb begin
    lg = (size_log2 == 4'd0) ? 4'd1 : size_log2;
    if ({28'd0, lg} >= AW) lg = 4'(AW);
    size = SW'(1) << lg;
    mask = AW'(size - SW'(1));
  end

  assign job_ready = st_r == S_IDLE;
  assign out_valid = ovalid_r;
  assign out_data  = obuf_r;
  assign clearing  = st_r == S_CLR;

  assign hit = occ_q == 3'd0 ||
               (ent_q.hi == job_r.hi && ent_q.mid == job_r.mid && ent_q.lo == job_r.lo);
  assign nc  = (occ_q == 3'd1) ? 3'd2 : (occ_q == 3'd2) ? 3'd3 :
               (occ_q == 3'd3) ? 3'd4 : 3'd3;
  assign wr_en = st_r == S_CHECK && hit && probes_r < size;

  always_ff @(posedge clk) begin
    if (st_r == S_CLR) begin
      occ_mem[clr_r] <= 3'd0;
    end else if (wr_en) begin
      occ_mem[h_r] <= (occ_q == 3'd0) ? 3'd1 : nc;
    end
    if (wr_en && occ_q == 3'd0) begin
      ent_mem[h_r] <= '{hi: job_r.hi, mid: job_r.mid, lo: job_r.lo,
                        elem: job_r.elem, face: job_r.face};
    end
    occ_q <= occ_mem[h_r];
    ent_q <= ent_mem[h_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      clr_r    <= '0;
      surf_r   <= '0;
      inner_r  <= '0;
      full_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (out_valid && out_ready && st_r != S_OUT) ovalid_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(TABLE_DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            if (job.clear) begin
              surf_r  <= '0;
              inner_r <= '0;
              full_r  <= 1'b0;
              clr_r   <= '0;
              st_r    <= S_CLR;
            end else begin
              hsum_r <= (VW+11)'(job.hi) + (VW+11)'(job.mid) * 17
                        + (VW+11)'(job.lo) * 513;
              st_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          h_r      <= AW'(hsum_r) & mask;
          probes_r <= '0;
          st_r     <= S_READ;
        end
        S_READ: st_r <= S_CHECK;
        S_CHECK: begin
          if (probes_r >= size) begin
            full_r <= 1'b1;
            res_r  <= '{this_element: job_r.elem, face_index: job_r.face, matched: 1'b0,
                        neighbor_element: '0, neighbor_face: 2'd0, surface_total: surf_r,
                        inner_total: inner_r, table_full: 1'b1, last: job_r.face == 2'd3};
            st_r   <= S_OUT;
          end else if (hit) begin
            if (occ_q == 3'd0) begin
              surf_r <= surf_r + CW'(1);
              res_r  <= '{this_element: job_r.elem, face_index: job_r.face, matched: 1'b0,
                          neighbor_element: '0, neighbor_face: 2'd0,
                          surface_total: surf_r + CW'(1), inner_total: inner_r,
                          table_full: full_r, last: job_r.face == 2'd3};
            end else if (nc[0]) begin
              surf_r  <= surf_r + CW'(1);
              inner_r <= inner_r - CW'(1);
              res_r  <= '{this_element: job_r.elem, face_index: job_r.face, matched: 1'b0,
                          neighbor_element: '0, neighbor_face: 2'd0,
                          surface_total: surf_r + CW'(1), inner_total: inner_r - CW'(1),
                          table_full: full_r, last: job_r.face == 2'd3};
            end else begin
              surf_r  <= surf_r - CW'(1);
              inner_r <= inner_r + CW'(1);
              res_r  <= '{this_element: job_r.elem, face_index: job_r.face,
                          matched: nc == 3'd2,
                          neighbor_element: (nc == 3'd2) ? ent_q.elem : '0,
                          neighbor_face: (nc == 3'd2) ? ent_q.face : 2'd0,
                          surface_total: surf_r - CW'(1), inner_total: inner_r + CW'(1),
                          table_full: full_r, last: job_r.face == 2'd3};
            end
            st_r <= S_OUT;
          end else begin
            h_r      <= (h_r + AW'(1)) & mask;
            probes_r <= probes_r + SW'(1);
            st_r     <= S_READ;
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_ready) begin
            obuf_r   <= res_r;
            ovalid_r <= 1'b1;
            st_r     <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/tetra_face_neighbor_matcher.sv
// Tetrahedron face neighbor matcher.
// Input channel (in_valid/in_ready/in_data): one transaction is either a
// clear command or a tetrahedron with its element number and four vertices.
// Result channel (out_valid/out_ready/out_data): four transactions per
// tetrahedron, one per face in face order, the fourth with last set; a clear
// gives none. cfg_we/cfg_wdata set log2 of the table size in use, and may be
// written only while the block is idle.
// Each face passes the engine's IDLE, HASH, READ and CHECK states and then
// OUT; every extra probe of the linear probing chain repeats READ and CHECK,
// as the hash table has a single read port. The engine takes a new face only
// once the result of the previous face is in the output register.
// The front part sorts each face into a canonical key and feeds a two-entry
// queue; the probe engine hashes, probes and updates the table.
// After reset, and after every clear, the engine sweeps the occurrence
// codes to zero, one entry per cycle over all TABLE_DEPTH entries, during which no
// input is accepted. A stalled receiver holds the one-entry result register
// and the engine waits behind it while the queue and front keep filling.
module tetra_face_neighbor_matcher #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tfnm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tfnm_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                 fr_valid, fr_ready, q_valid, q_ready, clearing, fr_in_ready;
  tfnm_pkg::face_job_t  fr_job, q_job;
  logic [3:0]           size_log2_r;

  // Hold off new transactions while the clearing sweep runs.
  assign in_ready = fr_in_ready && !clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= 4'd12;
    end else if (cfg_we) begin
      size_log2_r <= cfg_wdata;
    end
  end

  tfnm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid && !clearing), .in_ready(fr_in_ready), .in_data(in_data),
    .job_valid(fr_valid), .job_ready(fr_ready), .job(fr_job)
  );

  tfnm_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fr_valid), .wr_ready(fr_ready), .wr_data(fr_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  tfnm_probe #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_probe (
    .clk(clk), .rst_n(rst_n), .size_log2(size_log2_r),
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .clearing(clearing)
  );

  // A result never names a neighbor element without being flagged as a match.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.matched |-> out_data.neighbor_element == '0)
    else $error("neighbor given without match");

  // No input is taken during the clearing sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("input accepted while clearing");

  // A held result stays unchanged while the receiver stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

endmodule
